>>> hw/rtl/owd_pkg.sv
// shared types, constants and coefficient tables for the outline winding core
package owd_pkg;

    localparam int COORD_W    = 16;
    localparam int POINT_W    = 29;
    localparam int PROD_W     = 2 * POINT_W;
    localparam int SUM_W      = 64;
    localparam int COEF_W     = 10;
    localparam int CPROD_W    = COEF_W + 1 + COORD_W;
    localparam int STEP_W     = 3;
    localparam int CNT_W      = 2;
    localparam int SEGQ_DEPTH = 4;
    localparam int SEGQ_AW    = $clog2(SEGQ_DEPTH);
    localparam int SEGQ_CW    = $clog2(SEGQ_DEPTH + 1);
    localparam int RESQ_DEPTH = 4;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
    localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

    localparam logic [2:0] OP_MOVE  = 3'd0;
    localparam logic [2:0] OP_LINE  = 3'd1;
    localparam logic [2:0] OP_QUAD  = 3'd2;
    localparam logic [2:0] OP_CUBIC = 3'd3;
    localparam logic [2:0] OP_CLOSE = 3'd4;

    localparam logic [1:0] WIND_ZERO = 2'd0;
    localparam logic [1:0] WIND_POS  = 2'd1;
    localparam logic [1:0] WIND_NEG  = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(3);

    localparam logic [STEP_W-1:0] QUAD_LAST  = STEP_W'(5);
    localparam logic [STEP_W-1:0] CUBIC_LAST = STEP_W'(7);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};

    localparam logic [COEF_W-1:0] QUAD_C0 [8] = '{25, 16, 9, 4, 1, 0, 0, 0};
    localparam logic [COEF_W-1:0] QUAD_C1 [8] = '{10, 16, 18, 16, 10, 0, 0, 0};
    localparam logic [COEF_W-1:0] QUAD_C2 [8] = '{1, 4, 9, 16, 25, 36, 0, 0};

    localparam logic [COEF_W-1:0] CUBIC_C0 [8] = '{343, 216, 125, 64, 27, 8, 1, 0};
    localparam logic [COEF_W-1:0] CUBIC_C1 [8] = '{147, 216, 225, 192, 135, 72, 21, 0};
    localparam logic [COEF_W-1:0] CUBIC_C2 [8] = '{22, 80, 162, 256, 350, 432, 490, 512};

    typedef enum logic [2:0] {
        SEG_MOVE,
        SEG_LINE,
        SEG_QUAD,
        SEG_CUBIC,
        SEG_CLOSE,
        SEG_NONE
    } t_seg_kind;

    typedef enum logic [1:0] {
        TOK_POINT,
        TOK_CLOSE,
        TOK_NONE
    } t_tok_kind;

    typedef struct packed {
        logic [2:0]                opcode;
        logic signed [COORD_W-1:0] px1;
        logic signed [COORD_W-1:0] py1;
        logic signed [COORD_W-1:0] px2;
        logic signed [COORD_W-1:0] py2;
        logic signed [COORD_W-1:0] px3;
        logic signed [COORD_W-1:0] py3;
        logic                      last_segment;
    } t_in_item;

    typedef struct packed {
        logic [1:0] winding;
        logic       area_saturated;
    } t_out_item;

    typedef struct packed {
        t_seg_kind                 kind;
        logic [STEP_W-1:0]         last_step;
        logic                      last;
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
    } t_seg_entry;

    typedef struct packed {
        logic [COEF_W-1:0] c0;
        logic [COEF_W-1:0] c1;
        logic [COEF_W-1:0] c2;
    } t_coef;

    typedef struct packed {
        logic                      valid;
        t_tok_kind                 kind;
        logic                      last;
        logic signed [POINT_W-1:0] x;
        logic signed [POINT_W-1:0] y;
    } t_point_tok;

    function automatic t_seg_kind seg_classify(logic [2:0] opcode);
        t_seg_kind k;
        case (opcode)
            OP_MOVE:  k = SEG_MOVE;
            OP_LINE:  k = SEG_LINE;
            OP_QUAD:  k = SEG_QUAD;
            OP_CUBIC: k = SEG_CUBIC;
            OP_CLOSE: k = SEG_CLOSE;
            default:  k = SEG_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [STEP_W-1:0] seg_last_step(t_seg_kind kind);
        logic [STEP_W-1:0] s;
        case (kind)
            SEG_QUAD:  s = QUAD_LAST;
            SEG_CUBIC: s = CUBIC_LAST;
            default:   s = '0;
        endcase
        return s;
    endfunction

    function automatic t_coef seg_coef(t_seg_kind kind, logic [STEP_W-1:0] step);
        t_coef c;
        c = '0;
        case (kind)
            SEG_MOVE: begin
                c.c0 = COEF_W'(1);
            end
            SEG_LINE: begin
                c.c2 = COEF_W'(1);
            end
            SEG_QUAD: begin
                c.c0 = QUAD_C0[step];
                c.c1 = QUAD_C1[step];
                c.c2 = QUAD_C2[step];
            end
            SEG_CUBIC: begin
                c.c0 = CUBIC_C0[step];
                c.c1 = CUBIC_C1[step];
                c.c2 = CUBIC_C2[step];
            end
            default: begin
                c = '0;
            end
        endcase
        return c;
    endfunction

    function automatic t_tok_kind seg_tok_kind(t_seg_kind kind);
        t_tok_kind t;
        case (kind)
            SEG_MOVE, SEG_LINE, SEG_QUAD, SEG_CUBIC: t = TOK_POINT;
            SEG_CLOSE:                               t = TOK_CLOSE;
            default:                                 t = TOK_NONE;
        endcase
        return t;
    endfunction

    // weighted sum times 4608 (move, line), 128 (quad) or 9 (cubic)
    function automatic logic signed [POINT_W-1:0] seg_scale(t_seg_kind kind,
                                                          logic signed [POINT_W-1:0] s);
        logic signed [POINT_W-1:0] r;
        case (kind)
            SEG_MOVE, SEG_LINE: r = (s <<< 12) + (s <<< 9);
            SEG_QUAD:           r = s <<< 7;
            SEG_CUBIC:          r = (s <<< 3) + s;
            default:            r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/owd_front.sv
// front end: item intake, segment classification and segment queue
module owd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  owd_pkg::t_in_item    i_item,
    output logic                 o_head_valid,
    output owd_pkg::t_seg_entry  o_head,
    input  logic                 i_head_pop
);

    owd_pkg::t_seg_entry                r_mem [owd_pkg::SEGQ_DEPTH];
    logic [owd_pkg::SEGQ_AW-1:0]        r_wr;
    logic [owd_pkg::SEGQ_AW-1:0]        r_rd;
    logic [owd_pkg::SEGQ_CW-1:0]        r_cnt;
    owd_pkg::t_seg_entry                n_entry;
    owd_pkg::t_seg_kind                 kind;
    logic                               push_ok;
    logic                               pop_ok;

    always_comb begin
        kind              = owd_pkg::seg_classify(i_item.opcode);
        n_entry.kind      = kind;
        n_entry.last_step = owd_pkg::seg_last_step(kind);
        n_entry.last      = i_item.last_segment;
        n_entry.x0        = i_item.px1;
        n_entry.y0        = i_item.py1;
        n_entry.x1        = i_item.px2;
        n_entry.y1        = i_item.py2;
        n_entry.x2        = i_item.px3;
        n_entry.y2        = i_item.py3;
    end

    assign o_full       = (r_cnt == owd_pkg::SEGQ_CW'(owd_pkg::SEGQ_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];
    assign push_ok      = i_push && !o_full;
    assign pop_ok       = i_head_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/owd_points.sv
// back end, first half: step sequencer and flattened point generation
module owd_points (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_head_valid,
    input  owd_pkg::t_seg_entry           i_head,
    output logic                          o_head_pop,
    input  logic [owd_pkg::RESQ_CW-1:0]   i_pending,
    output owd_pkg::t_point_tok           o_tok
);

    logic [owd_pkg::STEP_W-1:0]             r_step;
    logic                                   r_s1_valid;
    logic                                   r_s1_last;
    owd_pkg::t_seg_kind                     r_s1_kind;
    logic signed [owd_pkg::CPROD_W-1:0]     r_s1_px [3];
    logic signed [owd_pkg::CPROD_W-1:0]     r_s1_py [3];
    owd_pkg::t_point_tok                    r_s2;
    owd_pkg::t_coef                         coef;
    logic signed [owd_pkg::CPROD_W-1:0]     n_px [3];
    logic signed [owd_pkg::CPROD_W-1:0]     n_py [3];
    logic signed [owd_pkg::POINT_W-1:0]     sum_x;
    logic signed [owd_pkg::POINT_W-1:0]     sum_y;
    logic [owd_pkg::RESQ_CW-1:0]            pending_all;
    logic                                   fin;
    logic                                   tok_last;
    logic                                   issue;

    always_comb begin
        fin         = (r_step == i_head.last_step);
        tok_last    = i_head.last && fin;
        pending_all = i_pending + owd_pkg::RESQ_CW'(r_s1_valid && r_s1_last)
                    + owd_pkg::RESQ_CW'(r_s2.valid && r_s2.last);
        issue       = i_head_valid
                    && (!tok_last
                        || pending_all < owd_pkg::RESQ_CW'(owd_pkg::RESQ_DEPTH));
        o_head_pop  = issue && fin;

        coef    = owd_pkg::seg_coef(i_head.kind, r_step);
        n_px[0] = $signed({1'b0, coef.c0}) * i_head.x0;
        n_px[1] = $signed({1'b0, coef.c1}) * i_head.x1;
        n_px[2] = $signed({1'b0, coef.c2}) * i_head.x2;
        n_py[0] = $signed({1'b0, coef.c0}) * i_head.y0;
        n_py[1] = $signed({1'b0, coef.c1}) * i_head.y1;
        n_py[2] = $signed({1'b0, coef.c2}) * i_head.y2;

        sum_x = owd_pkg::POINT_W'(r_s1_px[0]) + owd_pkg::POINT_W'(r_s1_px[1])
              + owd_pkg::POINT_W'(r_s1_px[2]);
        sum_y = owd_pkg::POINT_W'(r_s1_py[0]) + owd_pkg::POINT_W'(r_s1_py[1])
              + owd_pkg::POINT_W'(r_s1_py[2]);
    end

    assign o_tok = r_s2;

    always_ff @(posedge i_clk) begin
        r_s1_kind <= i_head.kind;
        r_s1_last <= tok_last;
        r_s1_px   <= n_px;
        r_s1_py   <= n_py;
    end

    always_ff @(posedge i_clk) begin
        r_s2.kind <= owd_pkg::seg_tok_kind(r_s1_kind);
        r_s2.last <= r_s1_last;
        r_s2.x    <= owd_pkg::seg_scale(r_s1_kind, sum_x);
        r_s2.y    <= owd_pkg::seg_scale(r_s1_kind, sum_y);
        if (!i_rst_n) begin
            r_step     <= '0;
            r_s1_valid <= 1'b0;
            r_s2.valid <= 1'b0;
        end else begin
            r_s1_valid <= issue;
            r_s2.valid <= r_s1_valid;
            if (issue) begin
                r_step <= fin ? '0 : r_step + 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/owd_area.sv
// back end, second half: cross products, saturating area sum and result queue
module owd_area (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  owd_pkg::t_point_tok           i_tok,
    output logic [owd_pkg::RESQ_CW-1:0]   o_pending,
    output logic                          o_empty,
    input  logic                          i_pop,
    output owd_pkg::t_out_item            o_res
);

    logic signed [owd_pkg::POINT_W-1:0]   r_start_x;
    logic signed [owd_pkg::POINT_W-1:0]   r_start_y;
    logic signed [owd_pkg::POINT_W-1:0]   r_prev_x;
    logic signed [owd_pkg::POINT_W-1:0]   r_prev_y;
    logic [owd_pkg::CNT_W-1:0]            r_count;
    logic                                 r_m_term;
    logic                                 r_m_end;
    logic                                 r_m_big;
    logic signed [owd_pkg::PROD_W-1:0]    r_p1;
    logic signed [owd_pkg::PROD_W-1:0]    r_p2;
    logic                                 r_t_term;
    logic                                 r_t_end;
    logic                                 r_t_big;
    logic signed [owd_pkg::PROD_W-1:0]    r_term;
    logic signed [owd_pkg::SUM_W-1:0]     r_sum;
    logic                                 r_sat;
    owd_pkg::t_out_item                   r_q [owd_pkg::RESQ_DEPTH];
    logic [owd_pkg::RESQ_AW-1:0]          r_wr;
    logic [owd_pkg::RESQ_AW-1:0]          r_rd;
    logic [owd_pkg::RESQ_CW-1:0]          r_qcnt;

    logic signed [owd_pkg::POINT_W-1:0]   pt_x;
    logic signed [owd_pkg::POINT_W-1:0]   pt_y;
    logic                                 add_pt;
    logic                                 has_prev;
    logic                                 tok_end;
    logic [owd_pkg::CNT_W-1:0]            cnt_up;
    logic [owd_pkg::CNT_W-1:0]            cnt_after;
    logic signed [owd_pkg::PROD_W-1:0]    n_p1;
    logic signed [owd_pkg::PROD_W-1:0]    n_p2;
    logic signed [owd_pkg::SUM_W:0]       sum_ext;
    logic signed [owd_pkg::SUM_W:0]       add_val;
    logic                                 ovf;
    logic signed [owd_pkg::SUM_W-1:0]     n_sum;
    logic                                 n_sat;
    owd_pkg::t_out_item                   n_res;
    logic                                 pop_ok;

    // point bookkeeping and cross product operands
    always_comb begin
        pt_x      = (i_tok.kind == owd_pkg::TOK_CLOSE) ? r_start_x : i_tok.x;
        pt_y      = (i_tok.kind == owd_pkg::TOK_CLOSE) ? r_start_y : i_tok.y;
        has_prev  = (r_count != '0);
        add_pt    = i_tok.valid
                  && ((i_tok.kind == owd_pkg::TOK_POINT)
                      || ((i_tok.kind == owd_pkg::TOK_CLOSE) && has_prev));
        tok_end   = i_tok.valid && i_tok.last;
        cnt_up    = (r_count == owd_pkg::COUNT_MAX) ? r_count : r_count + 1'b1;
        cnt_after = add_pt ? cnt_up : r_count;
        n_p1      = r_prev_x * pt_y;
        n_p2      = pt_x * r_prev_y;
    end

    // saturating accumulate and winding decision
    always_comb begin
        add_val = r_t_term ? (owd_pkg::SUM_W + 1)'(r_term) : '0;
        sum_ext = (owd_pkg::SUM_W + 1)'(r_sum) + add_val;
        ovf     = (sum_ext[owd_pkg::SUM_W] != sum_ext[owd_pkg::SUM_W-1]);
        if (ovf) begin
            n_sum = sum_ext[owd_pkg::SUM_W] ? owd_pkg::SUM_MIN : owd_pkg::SUM_MAX;
        end else begin
            n_sum = sum_ext[owd_pkg::SUM_W-1:0];
        end
        n_sat = r_sat || ovf;
        n_res.area_saturated = n_sat;
        if (!r_t_big || n_sum == '0) begin
            n_res.winding = owd_pkg::WIND_ZERO;
        end else if (n_sum[owd_pkg::SUM_W-1]) begin
            n_res.winding = owd_pkg::WIND_NEG;
        end else begin
            n_res.winding = owd_pkg::WIND_POS;
        end
    end

    assign pop_ok    = i_pop && !o_empty;
    assign o_empty   = (r_qcnt == '0);
    assign o_res     = r_q[r_rd];
    assign o_pending = r_qcnt + owd_pkg::RESQ_CW'(r_m_end) + owd_pkg::RESQ_CW'(r_t_end);

    always_ff @(posedge i_clk) begin
        r_m_big <= (cnt_after == owd_pkg::COUNT_MAX);
        r_p1    <= n_p1;
        r_p2    <= n_p2;
        r_t_big <= r_m_big;
        r_term  <= r_p1 - r_p2;
        if (r_t_end) begin
            r_q[r_wr] <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_count   <= '0;
            r_m_term  <= 1'b0;
            r_m_end   <= 1'b0;
            r_t_term  <= 1'b0;
            r_t_end   <= 1'b0;
            r_sum     <= '0;
            r_sat     <= 1'b0;
            r_wr      <= '0;
            r_rd      <= '0;
            r_qcnt    <= '0;
        end else begin
            r_m_term <= add_pt && has_prev;
            r_m_end  <= tok_end;
            r_t_term <= r_m_term;
            r_t_end  <= r_m_end;

            if (tok_end) begin
                r_start_x <= '0;
                r_start_y <= '0;
                r_prev_x  <= '0;
                r_prev_y  <= '0;
                r_count   <= '0;
            end else if (add_pt) begin
                if (!has_prev) begin
                    r_start_x <= pt_x;
                    r_start_y <= pt_y;
                end
                r_prev_x <= pt_x;
                r_prev_y <= pt_y;
                r_count  <= cnt_up;
            end

            if (r_t_end) begin
                r_sum <= '0;
                r_sat <= 1'b0;
            end else begin
                r_sum <= n_sum;
                r_sat <= n_sat;
            end

            if (r_t_end) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
            if (r_t_end && !pop_ok) begin
                r_qcnt <= r_qcnt + 1'b1;
            end else if (pop_ok && !r_t_end) begin
                r_qcnt <= r_qcnt - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/outline_winding_direction_core.sv
// Outline winding direction core: takes an outline as a queue of segments (move, line,
// quadratic, cubic, close), flattens curves into points scaled by 4608 (quadratics at six
// steps, cubics at eight), sums the shoelace cross products of consecutive points in a
// saturating 64-bit accumulator and, on the segment marked last, queues one result with
// the sign of the area (zero with fewer than three points) and the saturation flag.
// Segments wait in a four-entry queue; a single point sequencer then issues one flattened
// point per cycle, holding a segment marked last while the result queue could overflow.
// Move, line, close and unknown segments give one step. A result passes stages s1, s2,
// m and t into a four-entry result queue; intake stalls only on a full segment queue.
module outline_winding_direction_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  owd_pkg::t_in_item    i_item,
    output logic                 o_empty,
    input  logic                 i_pop,
    output owd_pkg::t_out_item   o_res
);

    logic                              head_valid;
    owd_pkg::t_seg_entry               head;
    logic                              head_pop;
    logic [owd_pkg::RESQ_CW-1:0]       pending;
    owd_pkg::t_point_tok               tok;

    owd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_item       (i_item),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_head_pop   (head_pop)
    );

    owd_points u_points (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_head_pop   (head_pop),
        .i_pending    (pending),
        .o_tok        (tok)
    );

    owd_area u_area (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tok     (tok),
        .o_pending (pending),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_res     (o_res)
    );

endmodule

>>> hw/rtl/owd_checker.sv
// port-level checks for the outline winding core and their bind
module owd_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_full,
    input logic                 o_empty,
    input logic                 i_pop,
    input owd_pkg::t_out_item   o_res
);

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queues not empty after reset");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_res)))
        else $error("waiting item changed or vanished");

    a_winding_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_res.winding == owd_pkg::WIND_ZERO
                      || o_res.winding == owd_pkg::WIND_POS
                      || o_res.winding == owd_pkg::WIND_NEG))
        else $error("bad winding code");

endmodule

bind outline_winding_direction_core owd_checker u_owd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_full  (o_full),
    .o_empty (o_empty),
    .i_pop   (i_pop),
    .o_res   (o_res)
);
